>>> sv/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the stream refresh scheduler.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int ENTRIES_DEF = 8;

   localparam logic [15:0] HB_PERIOD_RST = 16'd150;
   localparam logic [15:0] HB_TTL_RST    = 16'd300;
   localparam logic [31:0] HB_VAR_RST    = 32'd0;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_HB_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HB_TTL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HB_VAR    = 2'd2;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_OTHER = 2'd1,
      OP_TICK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic [31:0] var_id;
      logic        is_float;
      logic [31:0] value_bits;
      logic [15:0] ttl_ms;
   } req_type;

   typedef struct packed {
      logic [31:0] send_var_id;
      logic        send_is_float;
      logic [31:0] send_value;
      logic [15:0] send_ttl;
      logic        is_heartbeat;
   } rsp_type;

   // one row of the entry memory
   typedef struct packed {
      logic        is_float;
      logic [31:0] var_id;
      logic [15:0] ttl;
      logic [31:0] sent_at;
      logic [31:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> sv/srs_stream_if.sv
// ----------------------------------------------------------------------------
// srs_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface srs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/srs_ram.sv
// ----------------------------------------------------------------------------
// srs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/stream_refresh_scheduler_core.sv
// ----------------------------------------------------------------------------
// stream_refresh_scheduler_core
// Cache of recently sent stream variables with tick-driven resend/heartbeat.
// ----------------------------------------------------------------------------
// Store and tick beats scan the entry memory, one read per entry, then a
// decide state; a tick that resends an entry re-reads and stamps it in a fetch
// state; resends and heartbeats wait for a free result slot. The result beat
// is registered and shows the cycle after. Other-frame and clear beats stay idle.
// Reset is synchronous: valid bits, time and counter registers clear at once;
// the entry memory is not initialized and no clearing pass runs.
// ----------------------------------------------------------------------------
module stream_refresh_scheduler_core #(
   parameter int ENTRIES = srs_pkg::ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   srs_stream_if.sink                     req,
   srs_stream_if.source                   rsp,
   input  logic                           csr_wr_en,
   input  logic [srs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   // index into the entry memory, and a scan counter that can hold ENTRIES
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FETCH
   } state_type;

   // --------------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [ENTRIES-1:0]    used_ff, used_in;
   logic [31:0]           last_send_ff, last_send_in;
   logic [31:0]           hb_count_ff, hb_count_in;
   logic [15:0]           hb_period_ff, hb_period_in;
   logic [15:0]           hb_ttl_ff, hb_ttl_in;
   logic [31:0]           hb_var_ff, hb_var_in;

   // latched request beat
   srs_pkg::op_type       op_ff, op_in;
   logic [31:0]           now_ff, now_in;
   logic [31:0]           id_ff, id_in;
   logic                  flt_ff, flt_in;
   logic [31:0]           val_ff, val_in;
   logic [15:0]           ttl_ff, ttl_in;

   // scan results: key hit, first free, oldest, most expired
   logic                  hit_vld_ff, hit_vld_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic                  free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  old_vld_ff, old_vld_in;
   logic [IDX_W-1:0]      old_idx_ff, old_idx_in;
   logic [31:0]           old_age_ff, old_age_in;
   logic                  exp_vld_ff, exp_vld_in;
   logic [IDX_W-1:0]      exp_idx_ff, exp_idx_in;
   logic [31:0]           exp_age_ff, exp_age_in;
   logic [IDX_W-1:0]      pick_idx_ff, pick_idx_in;

   // result beat
   logic                  rsp_vld_ff, rsp_vld_in;
   srs_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   // --------------------------------------------------------------------------
   // Entry memory
   // --------------------------------------------------------------------------
   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   srs_pkg::entry_type            ram_wr_row;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [srs_pkg::ENTRY_W-1:0]   ram_rd_data;
   srs_pkg::entry_type            rd_row;

   srs_ram #(
      .WIDTH (srs_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_row),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_row = srs_pkg::entry_type'(ram_rd_data);

   // --------------------------------------------------------------------------
   // Handshake
   // --------------------------------------------------------------------------
   logic        req_fire;
   logic        rsp_free;
   logic        chk_used;
   logic [31:0] age;
   logic        quiet;
   logic        store_ok;
   logic [IDX_W-1:0] store_idx;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid = rsp_vld_ff;
   assign rsp.data  = rsp_data_ff;
   // result slot is free now or empties this cycle
   assign rsp_free  = !rsp_vld_ff || rsp.ready;

   assign chk_used  = used_ff[chk_idx_ff];
   assign age       = now_ff - rd_row.sent_at;
   // transmit silence test; a zero period always passes
   assign quiet     = (now_ff - last_send_ff) >= {16'd0, hb_period_ff};
   // existing key first, else lowest free entry; heartbeat id never cached
   assign store_ok  = (id_ff != hb_var_ff) && (hit_vld_ff || free_vld_ff);
   assign store_idx = hit_vld_ff ? hit_idx_ff : free_idx_ff;

   // --------------------------------------------------------------------------
   // Next-state logic
   // --------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      used_in      = used_ff;
      last_send_in = last_send_ff;
      hb_count_in  = hb_count_ff;
      hb_period_in = hb_period_ff;
      hb_ttl_in    = hb_ttl_ff;
      hb_var_in    = hb_var_ff;

      op_in  = op_ff;
      now_in = now_ff;
      id_in  = id_ff;
      flt_in = flt_ff;
      val_in = val_ff;
      ttl_in = ttl_ff;

      hit_vld_in  = hit_vld_ff;
      hit_idx_in  = hit_idx_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      old_vld_in  = old_vld_ff;
      old_idx_in  = old_idx_ff;
      old_age_in  = old_age_ff;
      exp_vld_in  = exp_vld_ff;
      exp_idx_in  = exp_idx_ff;
      exp_age_in  = exp_age_ff;
      pick_idx_in = pick_idx_ff;

      rsp_vld_in  = rsp_vld_ff && !rsp.ready;
      rsp_data_in = rsp_data_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = store_idx;
      ram_wr_row  = '{is_float: flt_ff, var_id: id_ff, ttl: ttl_ff,
                      sent_at: now_ff, value: val_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_ff[IDX_W-1:0];

      // the user must let register writes arrive only while idle; the block does not enforce this
      if (csr_wr_en) begin
         unique case (csr_index)
            srs_pkg::CSR_HB_PERIOD: hb_period_in = csr_wr_data[15:0];
            srs_pkg::CSR_HB_TTL:    hb_ttl_in    = csr_wr_data[15:0];
            srs_pkg::CSR_HB_VAR:    hb_var_in    = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = srs_pkg::op_type'(req.data.operation);
               now_in      = req.data.now_ms;
               id_in       = req.data.var_id;
               flt_in      = req.data.is_float;
               val_in      = req.data.value_bits;
               ttl_in      = req.data.ttl_ms;
               cnt_in      = '0;
               hit_vld_in  = 1'b0;
               free_vld_in = 1'b0;
               old_vld_in  = 1'b0;
               exp_vld_in  = 1'b0;
               unique case (srs_pkg::op_type'(req.data.operation))
                  srs_pkg::OP_STORE: begin
                     last_send_in = req.data.now_ms;
                     state_in     = ST_SCAN;
                  end
                  srs_pkg::OP_OTHER: last_send_in = req.data.now_ms;
                  srs_pkg::OP_TICK:  state_in     = ST_SCAN;
                  srs_pkg::OP_CLEAR: used_in      = '0;
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            // read one entry per cycle, compare it the cycle after
            if (cnt_ff < CNT_W'(ENTRIES)) begin
               ram_rd_en  = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[IDX_W-1:0];
            end else if (!chk_vld_ff) begin
               state_in = ST_DECIDE;
            end

            if (chk_vld_ff) begin
               if (chk_used) begin
                  if (!hit_vld_ff && rd_row.is_float == flt_ff &&
                      rd_row.var_id == id_ff) begin
                     hit_vld_in = 1'b1;
                     hit_idx_in = chk_idx_ff;
                  end
                  // strict compare: ties keep the lower entry
                  if (!old_vld_ff || age > old_age_ff) begin
                     old_vld_in = 1'b1;
                     old_idx_in = chk_idx_ff;
                     old_age_in = age;
                  end
                  if (rd_row.ttl != 16'd0 && age >= {16'd0, rd_row.ttl} &&
                      (!exp_vld_ff || age > exp_age_ff)) begin
                     exp_vld_in = 1'b1;
                     exp_idx_in = chk_idx_ff;
                     exp_age_in = age;
                  end
               end else if (!free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
         end

         ST_DECIDE: begin
            if (op_ff == srs_pkg::OP_STORE) begin
               if (store_ok) begin
                  ram_wr_en          = 1'b1;
                  used_in[store_idx] = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (exp_vld_ff || (quiet && old_vld_ff)) begin
               // re-read the chosen row for resend and stamping
               pick_idx_in = exp_vld_ff ? exp_idx_ff : old_idx_ff;
               ram_rd_en   = 1'b1;
               ram_rd_addr = exp_vld_ff ? exp_idx_ff : old_idx_ff;
               state_in    = ST_FETCH;
            end else if (quiet) begin
               // empty table: heartbeat
               if (rsp_free) begin
                  hb_count_in  = hb_count_ff + 32'd1;
                  last_send_in = now_ff;
                  rsp_vld_in   = 1'b1;
                  rsp_data_in  = '{send_var_id: hb_var_ff, send_is_float: 1'b0,
                                   send_value: hb_count_ff + 32'd1,
                                   send_ttl: hb_ttl_ff, is_heartbeat: 1'b1};
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_FETCH: begin
            // read data holds until the result slot frees up
            if (rsp_free) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = pick_idx_ff;
               ram_wr_row   = rd_row;
               ram_wr_row.sent_at = now_ff;
               last_send_in = now_ff;
               rsp_vld_in   = 1'b1;
               rsp_data_in  = '{send_var_id: rd_row.var_id,
                                send_is_float: rd_row.is_float,
                                send_value: rd_row.value, send_ttl: rd_row.ttl,
                                is_heartbeat: 1'b0};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------------------
   // State and registered outputs
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      op_ff       <= op_in;
      now_ff      <= now_in;
      id_ff       <= id_in;
      flt_ff      <= flt_in;
      val_ff      <= val_in;
      ttl_ff      <= ttl_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      old_idx_ff  <= old_idx_in;
      old_age_ff  <= old_age_in;
      exp_idx_ff  <= exp_idx_in;
      exp_age_ff  <= exp_age_in;
      pick_idx_ff <= pick_idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         used_ff      <= '0;
         last_send_ff <= '0;
         hb_count_ff  <= '0;
         hb_period_ff <= srs_pkg::HB_PERIOD_RST;
         hb_ttl_ff    <= srs_pkg::HB_TTL_RST;
         hb_var_ff    <= srs_pkg::HB_VAR_RST;
         hit_vld_ff   <= 1'b0;
         free_vld_ff  <= 1'b0;
         old_vld_ff   <= 1'b0;
         exp_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         used_ff      <= used_in;
         last_send_ff <= last_send_in;
         hb_count_ff  <= hb_count_in;
         hb_period_ff <= hb_period_in;
         hb_ttl_ff    <= hb_ttl_in;
         hb_var_ff    <= hb_var_in;
         hit_vld_ff   <= hit_vld_in;
         free_vld_ff  <= free_vld_in;
         old_vld_ff   <= old_vld_in;
         exp_vld_ff   <= exp_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stream_refresh_scheduler_core. A table of directed
// beats walks the reset state, the table edges and the heartbeat path. Random
// phases follow under several heartbeat settings and handshake idling mixes.
// Tick beats are scored against a cycle-free copy of the scheduler or a typed send.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES    = srs_pkg::ENTRIES_DEF;
   localparam int PHASES         = 8;
   localparam int PHASE_BEATS    = 200;
   // wait out a trailing store or tick scan; leave margin
   localparam int SETTLE_CYCLES  = NUM_ENTRIES + 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   // how a directed row is scored
   typedef enum logic [1:0] {
      CHK_MODEL,   // whatever the predictor says
      CHK_SILENT,  // no send beat at all
      CHK_SEND     // the send beat typed in the row
   } probe_check_type;

   typedef struct packed {
      probe_check_type  check;
      srs_pkg::op_type  op;
      logic [31:0]      now_ms;
      logic [31:0]      var_id;
      logic             is_float;
      logic [31:0]      value_bits;
      logic [15:0]      ttl_ms;
      srs_pkg::rsp_type send;
   } probe_row_type;

   localparam srs_pkg::rsp_type NO_SEND = '0;

   // ------------------------------------------------------------------------
   // Clock, reset and the channels
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_wr_en;
   logic [srs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [srs_pkg::CSR_DATA_W-1:0] csr_wr_data;

   srs_stream_if #(.payload_type(srs_pkg::req_type)) req_if ();
   srs_stream_if #(.payload_type(srs_pkg::rsp_type)) rsp_if ();

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stream_refresh_scheduler_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // Scheduler copy: configuration, entry table, time and heartbeat counter
   // ------------------------------------------------------------------------
   logic [15:0] cfg_period;
   logic [15:0] cfg_hb_ttl;
   logic [31:0] cfg_hb_var;

   logic        cache_used    [NUM_ENTRIES];
   logic        cache_float   [NUM_ENTRIES];
   logic [31:0] cache_var     [NUM_ENTRIES];
   logic [15:0] cache_ttl     [NUM_ENTRIES];
   logic [31:0] cache_sent_at [NUM_ENTRIES];
   logic [31:0] cache_value   [NUM_ENTRIES];
   logic [31:0] last_tx_ms;
   logic [31:0] hb_counter;

   srs_pkg::rsp_type pending_sends [$];   // send beats owed by the block, oldest first

   int          mismatches   = 0;
   int          quiet_cycles = 0;
   int          gap_pct      = 0;   // sender: chance of an empty cycle
   int          stall_pct    = 0;   // receiver: chance of holding ready low
   bit          hold_request = 1'b0;
   int          hold_left    = 0;
   logic [31:0] wall_ms      = 32'd0;

   // Directed beats. Times are chosen so that most ticks land exactly on or
   // just short of an expiry or the silence threshold.
   probe_row_type probes [25] = '{
      // empty table: silence threshold one short, then exactly met
      '{CHK_SILENT, srs_pkg::OP_TICK,  32'd0,   32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      '{CHK_SILENT, srs_pkg::OP_TICK,  32'd149, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      '{CHK_SEND,   srs_pkg::OP_TICK,  32'd150, 32'd0, 1'b0, 32'd0, 16'd0,
        '{32'd0, 1'b0, 32'd1, 16'd300, 1'b1}},
      // heartbeat id is never cached, but still counts as a send
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd160, 32'd0, 1'b1, 32'h1234_5678, 16'd5,
        NO_SEND},
      '{CHK_SILENT, srs_pkg::OP_TICK,  32'd309, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      '{CHK_SEND,   srs_pkg::OP_TICK,  32'd310, 32'd0, 1'b0, 32'd0, 16'd0,
        '{32'd0, 1'b0, 32'd2, 16'd300, 1'b1}},
      // all-ones key and value; same id under both types takes two entries
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd320, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
        16'hFFFF, NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd330, 32'd5, 1'b0, 32'h8000_0000, 16'd10,
        NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd335, 32'd5, 1'b1, 32'd7, 16'd0, NO_SEND},
      '{CHK_SILENT, srs_pkg::OP_TICK,  32'd339, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      '{CHK_SEND,   srs_pkg::OP_TICK,  32'd340, 32'd0, 1'b0, 32'd0, 16'd0,
        '{32'd5, 1'b0, 32'h8000_0000, 16'd10, 1'b0}},
      // update in place, then a foreign frame resets the silence clock
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd345, 32'd5, 1'b0, 32'd1, 16'd20, NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_OTHER, 32'd350, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_TICK,  32'd365, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      // fill the table at one instant so the ages tie
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd370, 32'd10, 1'b0, 32'h0000_00A0, 16'd5,
        NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd370, 32'd11, 1'b0, 32'h0000_00A1, 16'd5,
        NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd370, 32'd12, 1'b0, 32'h0000_00A2, 16'd5,
        NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd370, 32'd13, 1'b0, 32'h0000_00A3, 16'd5,
        NO_SEND},
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd370, 32'd14, 1'b0, 32'h0000_00A4, 16'd5,
        NO_SEND},
      // full: a new key is dropped
      '{CHK_MODEL,  srs_pkg::OP_STORE, 32'd371, 32'd15, 1'b1, 32'h0000_00A5, 16'd1,
        NO_SEND},
      // tie among the five fill entries: lowest index wins
      '{CHK_MODEL,  srs_pkg::OP_TICK,  32'd376, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      // far future: the all-ones entry is the oldest and expired
      '{CHK_SEND,   srs_pkg::OP_TICK,  32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, 16'd0,
        '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0}},
      // clear keeps the counter; silence measured across the time wrap
      '{CHK_MODEL,  srs_pkg::OP_CLEAR, 32'd0, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND},
      '{CHK_SEND,   srs_pkg::OP_TICK,  32'd150, 32'd0, 1'b0, 32'd0, 16'd0,
        '{32'd0, 1'b0, 32'd3, 16'd300, 1'b1}},
      '{CHK_SILENT, srs_pkg::OP_TICK,  32'd150, 32'd0, 1'b0, 32'd0, 16'd0, NO_SEND}
   };

   function automatic void clear_cache();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         cache_used[i]    = 1'b0;
         cache_float[i]   = 1'b0;
         cache_var[i]     = '0;
         cache_ttl[i]     = '0;
         cache_sent_at[i] = '0;
         cache_value[i]   = '0;
      end
   endfunction

   // Apply one input beat to the copy; returns 1 with the send beat it causes.
   function automatic bit predict_send(input srs_pkg::req_type beat,
                                       output srs_pkg::rsp_type send);
      int          slot;
      int          oldest;
      int          expired;
      int          pick;
      logic [31:0] age;
      logic [31:0] oldest_age;
      logic [31:0] expired_age;
      logic [31:0] silence;
      bit          quiet;

      send = '0;
      case (srs_pkg::op_type'(beat.operation))
         srs_pkg::OP_STORE: begin
            last_tx_ms = beat.now_ms;
            if (beat.var_id != cfg_hb_var) begin
               // matching key wins, else first free entry
               slot = -1;
               for (int i = 0; i < NUM_ENTRIES; i++) begin
                  if (cache_used[i] && cache_float[i] == beat.is_float &&
                      cache_var[i] == beat.var_id) begin
                     slot = i;
                     break;
                  end
                  if (!cache_used[i] && slot < 0)
                     slot = i;
               end
               if (slot >= 0) begin
                  cache_used[slot]    = 1'b1;
                  cache_float[slot]   = beat.is_float;
                  cache_var[slot]     = beat.var_id;
                  cache_ttl[slot]     = beat.ttl_ms;
                  cache_sent_at[slot] = beat.now_ms;
                  cache_value[slot]   = beat.value_bits;
               end
            end
            return 1'b0;
         end
         srs_pkg::OP_OTHER: begin
            last_tx_ms = beat.now_ms;
            return 1'b0;
         end
         srs_pkg::OP_CLEAR: begin
            clear_cache();
            return 1'b0;
         end
         default: begin
            silence     = beat.now_ms - last_tx_ms;
            quiet       = (silence >= {16'd0, cfg_period});
            oldest      = -1;
            expired     = -1;
            oldest_age  = '0;
            expired_age = '0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (cache_used[i]) begin
                  age = beat.now_ms - cache_sent_at[i];
                  // strict compares keep the lowest index on a tie
                  if (oldest < 0 || age > oldest_age) begin
                     oldest     = i;
                     oldest_age = age;
                  end
                  if (cache_ttl[i] != 16'd0 && age >= {16'd0, cache_ttl[i]} &&
                      (expired < 0 || age > expired_age)) begin
                     expired     = i;
                     expired_age = age;
                  end
               end
            end
            pick = (expired >= 0) ? expired : (quiet ? oldest : -1);
            if (pick >= 0) begin
               send.send_var_id   = cache_var[pick];
               send.send_is_float = cache_float[pick];
               send.send_value    = cache_value[pick];
               send.send_ttl      = cache_ttl[pick];
               send.is_heartbeat  = 1'b0;
               cache_sent_at[pick] = beat.now_ms;
               last_tx_ms          = beat.now_ms;
               return 1'b1;
            end
            if (oldest < 0 && quiet) begin
               hb_counter         = hb_counter + 32'd1;
               send.send_var_id   = cfg_hb_var;
               send.send_is_float = 1'b0;
               send.send_value    = hb_counter;
               send.send_ttl      = cfg_hb_ttl;
               send.is_heartbeat  = 1'b1;
               last_tx_ms         = beat.now_ms;
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Scoring of send beats
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_send(input srs_pkg::rsp_type got);
      srs_pkg::rsp_type want;
      if (pending_sends.size() == 0) begin
         $display("%0t: send beat with none expected, got %h", $time, got);
         mismatches++;
         return;
      end
      want = pending_sends.pop_front();
      compare_field("send_var_id",   want.send_var_id,   got.send_var_id);
      compare_field("send_is_float", want.send_is_float, got.send_is_float);
      compare_field("send_value",    want.send_value,    got.send_value);
      compare_field("send_ttl",      want.send_ttl,      got.send_ttl);
      compare_field("is_heartbeat",  want.is_heartbeat,  got.is_heartbeat);
   endfunction

   // Receiver. Random stalls per phase; on request a long hold-off counted
   // here, so the sender keeps pushing and the block backs up into req.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready)
            check_send(rsp_if.data);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Watchdog: too long with no beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Called at a rising edge; returns at the edge where the beat is taken.
   // valid stays high into the next beat unless a gap is rolled.
   task automatic deliver_beat(input srs_pkg::req_type beat, input probe_check_type check,
                               input srs_pkg::rsp_type typed);
      srs_pkg::rsp_type model_send;
      bit               has_send;
      while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= beat;
      do @(posedge clock); while (!req_if.ready);
      // the copy always advances; a typed row only overrides what is owed
      has_send = predict_send(beat, model_send);
      case (check)
         CHK_MODEL: if (has_send) pending_sends.push_back(model_send);
         CHK_SEND:  pending_sends.push_back(typed);
         default:   ;
      endcase
   endtask

   // Stop offering, wait out every owed send plus the scan of a trailing
   // store that owes nothing.
   task automatic drain_sends();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_sends.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes to period, TTL and id in consecutive cycles; upper data bits of the
   // 16-bit registers carry noise that the block must drop.
   task automatic program_heartbeat(input logic [15:0] period, input logic [15:0] hb_ttl,
                                    input logic [31:0] hb_id);
      csr_wr_en   <= 1'b1;
      csr_index   <= srs_pkg::CSR_HB_PERIOD;
      csr_wr_data <= {16'($urandom), period};
      @(posedge clock);
      csr_index   <= srs_pkg::CSR_HB_TTL;
      csr_wr_data <= {16'($urandom), hb_ttl};
      @(posedge clock);
      csr_index   <= srs_pkg::CSR_HB_VAR;
      csr_wr_data <= hb_id;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_period = period;
      cfg_hb_ttl = hb_ttl;
      cfg_hb_var = hb_id;
   endtask

   // Random beat: time mostly creeps forward so TTLs and the silence window
   // actually come due; a small id pool keeps hits, updates and a full table
   // frequent, with occasional heartbeat ids and arbitrary keys.
   function automatic srs_pkg::req_type random_beat();
      srs_pkg::req_type beat;
      int unsigned      roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)      beat.operation = srs_pkg::OP_STORE;
      else if (roll < 50) beat.operation = srs_pkg::OP_OTHER;
      else if (roll < 97) beat.operation = srs_pkg::OP_TICK;
      else                beat.operation = srs_pkg::OP_CLEAR;
      roll = $urandom_range(0, 99);
      if (roll < 90)      wall_ms = wall_ms + $urandom_range(0, 30);
      else if (roll < 98) wall_ms = wall_ms + $urandom_range(31, 600);
      else                wall_ms = $urandom;
      beat.now_ms = wall_ms;
      roll = $urandom_range(0, 99);
      if (roll < 85)      beat.var_id = $urandom_range(1, 6);
      else if (roll < 93) beat.var_id = cfg_hb_var;
      else                beat.var_id = $urandom;
      beat.is_float   = 1'($urandom_range(0, 1));
      beat.value_bits = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 15)      beat.ttl_ms = 16'd0;
      else if (roll < 90) beat.ttl_ms = 16'($urandom_range(1, 100));
      else                beat.ttl_ms = 16'($urandom_range(0, 65535));
      return beat;
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      srs_pkg::req_type beat;

      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_wr_en    <= 1'b0;
      csr_index    <= '0;
      csr_wr_data  <= '0;

      cfg_period = srs_pkg::HB_PERIOD_RST;
      cfg_hb_ttl = srs_pkg::HB_TTL_RST;
      cfg_hb_var = srs_pkg::HB_VAR_RST;
      clear_cache();
      last_tx_ms = '0;
      hb_counter = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows, reset configuration, no idling
      foreach (probes[i]) begin
         beat.operation  = probes[i].op;
         beat.now_ms     = probes[i].now_ms;
         beat.var_id     = probes[i].var_id;
         beat.is_float   = probes[i].is_float;
         beat.value_bits = probes[i].value_bits;
         beat.ttl_ms     = probes[i].ttl_ms;
         deliver_beat(beat, probes[i].check, probes[i].send);
      end
      drain_sends();

      // random phases: settings change only while the block is drained
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;   // keep reset settings
            1: program_heartbeat(16'd1, 16'd0, 32'hFFFF_FFFF);
            2: program_heartbeat(16'hFFFF, 16'hFFFF, $urandom);
            // zero period, heartbeat id collides with a pool id
            3: program_heartbeat(16'd0, 16'($urandom_range(0, 65535)), 32'd3);
            5: program_heartbeat(16'd50, 16'd300, 32'd0);
            default: program_heartbeat(16'($urandom_range(1, 400)),
                                       16'($urandom_range(0, 65535)), $urandom);
         endcase

         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 48; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 48; end
            default: begin gap_pct = 23; stall_pct = 23; end
         endcase

         // run time across the 32-bit wrap, with the receiver backed up
         if (phase == 4) begin
            wall_ms      = 32'hFFFF_FF00;
            hold_request = 1'b1;
         end

         for (int n = 0; n < PHASE_BEATS; n++) begin
            // mid-phase the sender goes quiet until every send is back
            if (phase == 5 && n == PHASE_BEATS / 2) begin
               req_if.valid <= 1'b0;
               do @(posedge clock); while (pending_sends.size() != 0);
            end
            deliver_beat(random_beat(), CHK_MODEL, NO_SEND);
         end
         drain_sends();
      end

      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

>>> files.f
sv/srs_pkg.sv
sv/srs_stream_if.sv
sv/srs_ram.sv
sv/stream_refresh_scheduler_core.sv
bench/tb_top.sv
